FILE: src/lfu_page_replacement_core_macros.svh
// Assertion macros for the LFU page replacement core.
// Used by the top level only; no other dependencies.
`ifndef LFU_PAGE_REPLACEMENT_CORE_MACROS_SVH
`define LFU_PAGE_REPLACEMENT_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LFU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfu assertion failed");

// Next-cycle implication, disabled during reset.
`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfu assertion failed");

`endif

FILE: src/lfu_pkg.sv
// Shared types, constants and helpers for the LFU page replacement core.
// No dependencies.
`default_nettype none

package lfu_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int PAGE_BITS  = 16;
    localparam int CNT_W      = 32;
    localparam int FIU_W      = 5;
    localparam int FIDX_W     = 4;

    localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;
    localparam logic [CNT_W-1:0] SAT_MAX   = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic vld;
        logic hit_found;
        logic emp_found;
        logic min_set;
    } t_scan_flags;

    typedef struct packed {
        logic en;
        logic hit;
    } t_upd_ctl;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == SAT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

FILE: src/lfu_if.sv
// Channel interfaces for the LFU page replacement core: page references in,
// replacement results out. Depends on lfu_pkg.
`default_nettype none

interface lfu_in_if #(
    parameter int PAGE_BITS = lfu_pkg::PAGE_BITS
);
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page;

    modport source (output valid, output page, input ready);
    modport sink   (input valid, input page, output ready);
endinterface

interface lfu_out_if #(
    parameter int PAGE_BITS = lfu_pkg::PAGE_BITS
);
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [lfu_pkg::FIDX_W-1:0]  frame_index;
    logic                        evicted_valid;
    logic [PAGE_BITS-1:0]        evicted_page;
    logic [lfu_pkg::CNT_W-1:0]   fault_total;

    modport source (output valid, output hit, output frame_index, output evicted_valid,
                    output evicted_page, output fault_total, input ready);
    modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                    input evicted_page, input fault_total, output ready);
endinterface

`default_nettype wire

FILE: src/lfu_cell.sv
// One frame cell: holds a frame's tag, use count and last-use tick, folds itself
// into the passing scan record and registers it for its neighbor. Depends on lfu_pkg.
`default_nettype none

module lfu_cell #(
    parameter int               PAGE_BITS = lfu_pkg::PAGE_BITS,
    parameter int               IDX_W     = 4,
    parameter logic [IDX_W-1:0] INDEX     = '0
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_active,
    input  wire lfu_pkg::t_scan_flags      i_flags,
    input  wire logic [PAGE_BITS-1:0]      i_page,
    input  wire logic [IDX_W-1:0]          i_hit_idx,
    input  wire logic [IDX_W-1:0]          i_emp_idx,
    input  wire logic [IDX_W-1:0]          i_min_idx,
    input  wire logic [lfu_pkg::CNT_W-1:0] i_min_cnt,
    input  wire logic [lfu_pkg::CNT_W-1:0] i_min_tick,
    input  wire logic [PAGE_BITS-1:0]      i_min_page,
    input  wire lfu_pkg::t_upd_ctl         i_upd,
    input  wire logic [IDX_W-1:0]          i_upd_idx,
    input  wire logic [PAGE_BITS-1:0]      i_upd_page,
    input  wire logic [lfu_pkg::CNT_W-1:0] i_upd_tick,
    output lfu_pkg::t_scan_flags           o_flags,
    output logic [PAGE_BITS-1:0]           o_page,
    output logic [IDX_W-1:0]               o_hit_idx,
    output logic [IDX_W-1:0]               o_emp_idx,
    output logic [IDX_W-1:0]               o_min_idx,
    output logic [lfu_pkg::CNT_W-1:0]      o_min_cnt,
    output logic [lfu_pkg::CNT_W-1:0]      o_min_tick,
    output logic [PAGE_BITS-1:0]           o_min_page
);

    logic                      r_valid;
    logic [PAGE_BITS-1:0]      r_page;
    logic [lfu_pkg::CNT_W-1:0] r_cnt;
    logic [lfu_pkg::CNT_W-1:0] r_tick;

    lfu_pkg::t_scan_flags      r_flags, n_flags;
    logic [PAGE_BITS-1:0]      r_rec_page;
    logic [IDX_W-1:0]          r_hit_idx, n_hit_idx;
    logic [IDX_W-1:0]          r_emp_idx, n_emp_idx;
    logic [IDX_W-1:0]          r_min_idx, n_min_idx;
    logic [lfu_pkg::CNT_W-1:0] r_min_cnt, n_min_cnt;
    logic [lfu_pkg::CNT_W-1:0] r_min_tick, n_min_tick;
    logic [PAGE_BITS-1:0]      r_min_page, n_min_page;

    logic match;
    logic empty;
    logic better;
    logic upd_me;

    assign match  = i_active && r_valid && (r_page == i_page);
    assign empty  = i_active && !r_valid;
    assign better = i_active && r_valid &&
                    (!i_flags.min_set || (r_cnt < i_min_cnt) ||
                     ((r_cnt == i_min_cnt) && (r_tick < i_min_tick)));
    assign upd_me = i_upd.en && (i_upd_idx == INDEX);

    always_comb begin
        n_flags           = i_flags;
        n_hit_idx         = i_hit_idx;
        n_emp_idx         = i_emp_idx;
        n_min_idx         = i_min_idx;
        n_min_cnt         = i_min_cnt;
        n_min_tick        = i_min_tick;
        n_min_page        = i_min_page;
        if (match && !i_flags.hit_found) begin
            n_flags.hit_found = 1'b1;
            n_hit_idx         = INDEX;
        end
        if (empty && !i_flags.emp_found) begin
            n_flags.emp_found = 1'b1;
            n_emp_idx         = INDEX;
        end
        if (better) begin
            n_flags.min_set = 1'b1;
            n_min_idx       = INDEX;
            n_min_cnt       = r_cnt;
            n_min_tick      = r_tick;
            n_min_page      = r_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
            if (upd_me) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec_page <= i_page;
        r_hit_idx  <= n_hit_idx;
        r_emp_idx  <= n_emp_idx;
        r_min_idx  <= n_min_idx;
        r_min_cnt  <= n_min_cnt;
        r_min_tick <= n_min_tick;
        r_min_page <= n_min_page;
        if (upd_me) begin
            r_tick <= i_upd_tick;
            if (i_upd.hit) begin
                r_cnt <= lfu_pkg::sat_inc(r_cnt);
            end else begin
                r_page <= i_upd_page;
                r_cnt  <= lfu_pkg::CNT_W'(1);
            end
        end
    end

    assign o_flags    = r_flags;
    assign o_page     = r_rec_page;
    assign o_hit_idx  = r_hit_idx;
    assign o_emp_idx  = r_emp_idx;
    assign o_min_idx  = r_min_idx;
    assign o_min_cnt  = r_min_cnt;
    assign o_min_tick = r_min_tick;
    assign o_min_page = r_min_page;

endmodule

`default_nettype wire

FILE: src/lfu_page_replacement_core.sv
// Top level of the LFU page replacement core (LRU tie-break): controller, chain
// of frame cells, counters and output register. Depends on lfu_pkg, lfu_if, lfu_cell.
//
// Usage:
//   i_in carries one page reference per transaction; o_out returns one result per
//   reference: hit, frame index, evicted page and the running fault total.
//   i_cfg_we/i_cfg_wdata write frames_in_use (0 acts as 1, values above
//   MAX_FRAMES act as MAX_FRAMES); write it only while the core is idle.
//   A reference walks the chain of MAX_FRAMES cells, one cell per cycle; each cell
//   checks its tag and folds its count and tick into the victim search.
//   One reference in flight at a time: a new reference is accepted only after the
//   previous one has walked the whole cell chain and its result has been loaded.
//   The output register holds a finished result while the next reference is
//   accepted and scanned; if the receiver stalls, the frame update and result
//   load wait until the output register frees up.
//   Reset: all frames empty, counters zero, frames_in_use = 16, no result pending.
`default_nettype none
`include "lfu_page_replacement_core_macros.svh"

module lfu_page_replacement_core #(
    parameter int MAX_FRAMES = lfu_pkg::MAX_FRAMES,
    parameter int PAGE_BITS  = lfu_pkg::PAGE_BITS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [lfu_pkg::FIU_W-1:0] i_cfg_wdata,
    lfu_in_if.sink                         i_in,
    lfu_out_if.source                      o_out
);

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW    = lfu_pkg::CNT_W;

    lfu_pkg::t_state r_state, n_state;

    logic [lfu_pkg::FIU_W-1:0] r_fiu;
    logic [CW-1:0]             r_tick;
    logic [CW-1:0]             r_faults;

    lfu_pkg::t_scan_flags c_flags [0:MAX_FRAMES];
    logic [PAGE_BITS-1:0] c_page     [0:MAX_FRAMES];
    logic [IDX_W-1:0]     c_hit_idx  [0:MAX_FRAMES];
    logic [IDX_W-1:0]     c_emp_idx  [0:MAX_FRAMES];
    logic [IDX_W-1:0]     c_min_idx  [0:MAX_FRAMES];
    logic [CW-1:0]        c_min_cnt  [0:MAX_FRAMES];
    logic [CW-1:0]        c_min_tick [0:MAX_FRAMES];
    logic [PAGE_BITS-1:0] c_min_page [0:MAX_FRAMES];

    lfu_pkg::t_scan_flags r_res_flags;
    logic [PAGE_BITS-1:0] r_res_page;
    logic [IDX_W-1:0]     r_res_hit_idx;
    logic [IDX_W-1:0]     r_res_emp_idx;
    logic [IDX_W-1:0]     r_res_min_idx;
    logic [PAGE_BITS-1:0] r_res_min_page;

    logic                        r_out_valid;
    logic                        r_out_hit;
    logic [lfu_pkg::FIDX_W-1:0]  r_out_idx;
    logic                        r_out_ev_valid;
    logic [PAGE_BITS-1:0]        r_out_ev_page;
    logic [CW-1:0]               r_out_faults;

    logic              in_ready;
    logic              in_accept;
    logic              out_free;
    logic              tail_vld;
    lfu_pkg::t_upd_ctl upd;
    logic [IDX_W-1:0]  sel_idx;
    logic              ev_valid;
    logic [CW-1:0]     faults_next;

    assign in_accept = i_in.valid && in_ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign tail_vld  = c_flags[MAX_FRAMES].vld;

    // head of the chain
    assign c_flags[0]    = '{vld: in_accept, default: 1'b0};
    assign c_page[0]     = i_in.page;
    assign c_hit_idx[0]  = '0;
    assign c_emp_idx[0]  = '0;
    assign c_min_idx[0]  = '0;
    assign c_min_cnt[0]  = '0;
    assign c_min_tick[0] = '0;
    assign c_min_page[0] = '0;

    assign sel_idx     = r_res_flags.hit_found ? r_res_hit_idx :
                         r_res_flags.emp_found ? r_res_emp_idx : r_res_min_idx;
    assign ev_valid    = !r_res_flags.hit_found && !r_res_flags.emp_found;
    assign faults_next = r_res_flags.hit_found ? r_faults : lfu_pkg::sat_inc(r_faults);

    genvar k;
    generate
        for (k = 0; k < MAX_FRAMES; k++) begin : g_cell
            logic active;
            assign active = (k == 0) || (32'(r_fiu) > k);

            lfu_cell #(
                .PAGE_BITS (PAGE_BITS),
                .IDX_W     (IDX_W),
                .INDEX     (IDX_W'(k))
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_active   (active),
                .i_flags    (c_flags[k]),
                .i_page     (c_page[k]),
                .i_hit_idx  (c_hit_idx[k]),
                .i_emp_idx  (c_emp_idx[k]),
                .i_min_idx  (c_min_idx[k]),
                .i_min_cnt  (c_min_cnt[k]),
                .i_min_tick (c_min_tick[k]),
                .i_min_page (c_min_page[k]),
                .i_upd      (upd),
                .i_upd_idx  (sel_idx),
                .i_upd_page (r_res_page),
                .i_upd_tick (r_tick),
                .o_flags    (c_flags[k+1]),
                .o_page     (c_page[k+1]),
                .o_hit_idx  (c_hit_idx[k+1]),
                .o_emp_idx  (c_emp_idx[k+1]),
                .o_min_idx  (c_min_idx[k+1]),
                .o_min_cnt  (c_min_cnt[k+1]),
                .o_min_tick (c_min_tick[k+1]),
                .o_min_page (c_min_page[k+1])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        case (r_state)
            lfu_pkg::ST_IDLE: begin
                if (in_accept) n_state = lfu_pkg::ST_SCAN;
            end
            lfu_pkg::ST_SCAN: begin
                if (tail_vld) n_state = lfu_pkg::ST_DONE;
            end
            lfu_pkg::ST_DONE: begin
                if (out_free) n_state = lfu_pkg::ST_IDLE;
            end
            default: n_state = lfu_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        upd      = '0;
        case (r_state)
            lfu_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            lfu_pkg::ST_DONE: begin
                upd.en  = out_free;
                upd.hit = r_res_flags.hit_found;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lfu_pkg::ST_IDLE;
            r_fiu       <= lfu_pkg::FIU_RESET;
            r_tick      <= '0;
            r_faults    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_fiu <= i_cfg_wdata;
            end
            if (upd.en) begin
                r_tick      <= lfu_pkg::sat_inc(r_tick);
                r_faults    <= faults_next;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lfu_pkg::ST_SCAN && tail_vld) begin
            r_res_flags    <= c_flags[MAX_FRAMES];
            r_res_page     <= c_page[MAX_FRAMES];
            r_res_hit_idx  <= c_hit_idx[MAX_FRAMES];
            r_res_emp_idx  <= c_emp_idx[MAX_FRAMES];
            r_res_min_idx  <= c_min_idx[MAX_FRAMES];
            r_res_min_page <= c_min_page[MAX_FRAMES];
        end
        if (upd.en) begin
            r_out_hit      <= r_res_flags.hit_found;
            r_out_idx      <= lfu_pkg::FIDX_W'(sel_idx);
            r_out_ev_valid <= ev_valid;
            r_out_ev_page  <= ev_valid ? r_res_min_page : '0;
            r_out_faults   <= faults_next;
        end
    end

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.hit           = r_out_hit;
    assign o_out.frame_index   = r_out_idx;
    assign o_out.evicted_valid = r_out_ev_valid;
    assign o_out.evicted_page  = r_out_ev_page;
    assign o_out.fault_total   = r_out_faults;

    `LFU_ASSERT_SAME(a_tail_in_scan, i_clk, i_rst_n, tail_vld, r_state == lfu_pkg::ST_SCAN)
    `LFU_ASSERT_NEXT(a_accept_blocks, i_clk, i_rst_n, in_accept, !i_in.ready)
    `LFU_ASSERT_NEXT(a_update_shows, i_clk, i_rst_n, upd.en, o_out.valid)
    `LFU_ASSERT_SAME(a_hit_no_evict, i_clk, i_rst_n, o_out.valid && o_out.hit, !o_out.evicted_valid)

endmodule

`default_nettype wire
